// File: hdl/vector_window_average_decimator_defines.svh
// ----------------------------------------------------------------------------
// Vector window average decimator: assertion macros
// Shared concurrent assertion forms used at the end of the front and back end modules.
// ----------------------------------------------------------------------------
`ifndef VECTOR_WINDOW_AVERAGE_DECIMATOR_DEFINES_SVH
`define VECTOR_WINDOW_AVERAGE_DECIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VWAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VWAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vwad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector window average decimator package
// Widths, sizes and the command type passed from the front to the back end.
// ----------------------------------------------------------------------------
package vwad_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_WINDOW   = 1024;

    localparam int IDX_W  = 8;
    localparam int VAL_W  = 32;
    localparam int TIME_W = 32;
    localparam int ACC_W  = 42;
    localparam int LEN_W  = 11;
    localparam int POS_W  = 10;

    // Both vectors share one sum memory, addressed by {vector_select, element_index}.
    localparam int MEM_DEPTH = 2 * MAX_ELEMENTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    typedef struct packed {
        logic                    vector_select;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] element_value;
        logic [ACC_W-1:0]        time_total;
        logic [LEN_W-1:0]        length;
        logic                    final_sample;
        logic                    end_of_sample;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend_a;
        logic [ACC_W-1:0] dividend_b;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] quot_a;
        logic [ACC_W-1:0] quot_b;
    } t_div_rsp;

endpackage

// File: hdl/vwad_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input element channel
// Valid/ready channel carrying one vector element per transfer.
// ----------------------------------------------------------------------------
interface vwad_in_if;
    import vwad_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    vector_select;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
    logic [TIME_W-1:0]       sample_time;
    logic                    end_of_sample;

    modport source (
        output valid, vector_select, element_index, element_value, sample_time,
               end_of_sample,
        input  ready
    );

    modport sink (
        input  valid, vector_select, element_index, element_value, sample_time,
               end_of_sample,
        output ready
    );
endinterface

// File: hdl/vwad_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Averaged element channel
// Valid/ready channel carrying one averaged element per transfer.
// ----------------------------------------------------------------------------
interface vwad_out_if;
    import vwad_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    out_vector_select;
    logic [IDX_W-1:0]        out_element_index;
    logic signed [VAL_W-1:0] average_value;
    logic [TIME_W-1:0]       average_time;
    logic                    last_of_output;

    modport source (
        output valid, out_vector_select, out_element_index, average_value,
               average_time, last_of_output,
        input  ready
    );

    modport sink (
        input  valid, out_vector_select, out_element_index, average_value,
               average_time, last_of_output,
        output ready
    );
endinterface

// File: hdl/vwad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-lane restoring divider
// Divides two unsigned dividends by one shared divisor, one quotient bit per
// cycle in each lane.
// ----------------------------------------------------------------------------
module vwad_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vwad_pkg::t_div_req i_req,
    output vwad_pkg::t_div_rsp o_rsp
);
    import vwad_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [LEN_W-1:0]     r_divisor;
    logic [LEN_W-1:0]     r_rem_a;
    logic [LEN_W-1:0]     r_rem_b;
    logic [ACC_W-1:0]     r_quo_a;
    logic [ACC_W-1:0]     r_quo_b;
    logic [LEN_W+ACC_W-1:0] step_a;
    logic [LEN_W+ACC_W-1:0] step_b;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [LEN_W+ACC_W-1:0] div_step(
        input logic [LEN_W-1:0] rem,
        input logic [ACC_W-1:0] quo,
        input logic [LEN_W-1:0] dvs
    );
        logic [LEN_W:0]   sh;
        logic [LEN_W+1:0] diff;
        sh   = {rem, quo[ACC_W-1]};
        diff = {1'b0, sh} - {2'b00, dvs};
        if (diff[LEN_W+1]) begin
            div_step = {sh[LEN_W-1:0], quo[ACC_W-2:0], 1'b0};
        end else begin
            div_step = {diff[LEN_W-1:0], quo[ACC_W-2:0], 1'b1};
        end
    endfunction

    assign step_a = div_step(r_rem_a, r_quo_a, r_divisor);
    assign step_b = div_step(r_rem_b, r_quo_b, r_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= DIV_CNT_W'(ACC_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_divisor <= i_req.divisor;
            r_rem_a   <= '0;
            r_rem_b   <= '0;
            r_quo_a   <= i_req.dividend_a;
            r_quo_b   <= i_req.dividend_b;
        end else if (r_cnt != '0) begin
            {r_rem_a, r_quo_a} <= step_a;
            {r_rem_b, r_quo_b} <= step_b;
        end
    end

    assign o_rsp.busy   = (r_cnt != '0);
    assign o_rsp.done   = r_done;
    assign o_rsp.quot_a = r_quo_a;
    assign o_rsp.quot_b = r_quo_b;
endmodule

// File: hdl/vwad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front and back end.
// ----------------------------------------------------------------------------
module vwad_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vwad_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output vwad_pkg::t_cmd    o_head,
    output vwad_pkg::t_q_stat o_stat
);
    import vwad_pkg::*;

    t_cmd              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head       = r_entries[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
endmodule

// File: hdl/vwad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts elements, holds the window length, position and time sum, and
// classifies each element as part of a final sample or not.
// ----------------------------------------------------------------------------
`include "vector_window_average_decimator_defines.svh"

module vwad_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vwad_in_if.sink                        i_in,
    input  logic                           i_cfg_wr_en,
    input  logic [vwad_pkg::LEN_W-1:0]     i_cfg_wr_data,
    input  vwad_pkg::t_q_stat              i_q_stat,
    input  logic                           i_clear_done,
    output logic                           o_push,
    output vwad_pkg::t_cmd                 o_cmd
);
    import vwad_pkg::*;

    logic [LEN_W-1:0] r_win_len;
    logic [POS_W-1:0] r_win_pos;
    logic [ACC_W-1:0] r_time_sum;
    logic [LEN_W-1:0] len_eff;
    logic [ACC_W-1:0] time_total;
    logic             final_sample;

    // A length of zero acts as one; anything above the maximum is clamped.
    always_comb begin
        if (r_win_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_win_len > LEN_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = r_win_len;
        end
    end

    assign final_sample = ({1'b0, r_win_pos} + LEN_W'(1)) >= len_eff;
    assign time_total   = r_time_sum + ACC_W'(i_in.sample_time);

    assign i_in.ready = !i_q_stat.full && i_clear_done;
    assign o_push     = i_in.valid && i_in.ready;

    assign o_cmd.vector_select = i_in.vector_select;
    assign o_cmd.element_index = i_in.element_index;
    assign o_cmd.element_value = i_in.element_value;
    assign o_cmd.time_total    = time_total;
    assign o_cmd.length        = len_eff;
    assign o_cmd.final_sample  = final_sample;
    assign o_cmd.end_of_sample = i_in.end_of_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= LEN_W'(1);
            r_win_pos  <= '0;
            r_time_sum <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win_len <= i_cfg_wr_data;
            end
            if (o_push && i_in.end_of_sample) begin
                if (final_sample) begin
                    r_win_pos  <= '0;
                    r_time_sum <= '0;
                end else begin
                    r_win_pos  <= r_win_pos + 1'b1;
                    r_time_sum <= time_total;
                end
            end
        end
    end

    `VWAD_ASSERT_NEXT(a_window_restarts, i_clk, i_rst_n, o_push && i_in.end_of_sample && final_sample, (r_win_pos == '0) && (r_time_sum == '0), "window did not restart after its final sample")
    `VWAD_ASSERT_IMPLY(a_no_accept_in_clear, i_clk, i_rst_n, o_push, i_clear_done, "element taken during the memory clearing pass")
    `VWAD_ASSERT_IMPLY(a_push_needs_room, i_clk, i_rst_n, o_push, !i_q_stat.full, "element pushed into a full queue")
endmodule

// File: hdl/vwad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Clears the sum memory after reset, then updates one sum per element and,
// in a final sample, divides sum and time by the window length.
// ----------------------------------------------------------------------------
`include "vector_window_average_decimator_defines.svh"

module vwad_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vwad_pkg::t_cmd    i_head,
    input  vwad_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_clear_done,
    vwad_out_if.source        o_out
);
    import vwad_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_START  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_back_state;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    t_cmd              r_cmd;
    logic [ACC_W-1:0]  r_sum_mem [MEM_DEPTH];
    logic [ACC_W-1:0]  r_rdata;
    logic [ACC_W-1:0]  r_sum;
    logic              r_neg;

    logic                    r_out_valid;
    logic                    r_out_sel;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [VAL_W-1:0] r_out_avg;
    logic [TIME_W-1:0]       r_out_time;
    logic                    r_out_last;

    logic [ACC_W-1:0]  sum_new;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ACC_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_load;
    logic [VAL_W-1:0]  avg_value;
    logic [TIME_W-1:0] avg_time;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    vwad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign sum_new   = r_rdata + {{(ACC_W-VAL_W){r_cmd.element_value[VAL_W-1]}},
                                  r_cmd.element_value};
    assign mem_raddr = {i_head.vector_select, i_head.element_index};

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        out_load  = 1'b0;
        div_req.start = 1'b0;
        // The value divider works on the magnitude; the sign is restored on emit.
        div_req.dividend_a = r_sum[ACC_W-1] ? (~r_sum + 1'b1) : r_sum;
        div_req.dividend_b = r_cmd.time_total;
        div_req.divisor    = r_cmd.length;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_we    = 1'b1;
                mem_waddr = {r_cmd.vector_select, r_cmd.element_index};
                mem_wdata = r_cmd.final_sample ? '0 : sum_new;
                n_state   = r_cmd.final_sample ? ST_START : ST_IDLE;
            end
            ST_START: begin
                div_req.start = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (!r_neg) begin
            if (div_rsp.quot_a > ACC_W'(32'h7FFF_FFFF)) begin
                avg_value = 32'h7FFF_FFFF;
            end else begin
                avg_value = div_rsp.quot_a[VAL_W-1:0];
            end
        end else begin
            if (div_rsp.quot_a > ACC_W'(32'h8000_0000)) begin
                avg_value = 32'h8000_0000;
            end else begin
                avg_value = ~div_rsp.quot_a[VAL_W-1:0] + 1'b1;
            end
        end
        if (div_rsp.quot_b[ACC_W-1:TIME_W] != '0) begin
            avg_time = '1;
        end else begin
            avg_time = div_rsp.quot_b[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sum_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_sum_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == ST_UPDATE) begin
            r_sum <= sum_new;
        end
        if (r_state == ST_START) begin
            r_neg <= r_sum[ACC_W-1];
        end
        if (out_load) begin
            r_out_sel  <= r_cmd.vector_select;
            r_out_idx  <= r_cmd.element_index;
            r_out_avg  <= avg_value;
            r_out_time <= avg_time;
            r_out_last <= r_cmd.end_of_sample;
        end
    end

    assign o_clear_done            = (r_state != ST_CLEAR);
    assign o_out.valid             = r_out_valid;
    assign o_out.out_vector_select = r_out_sel;
    assign o_out.out_element_index = r_out_idx;
    assign o_out.average_value     = r_out_avg;
    assign o_out.average_time      = r_out_time;
    assign o_out.last_of_output    = r_out_last;

    `VWAD_ASSERT_IMPLY(a_div_start_when_free, i_clk, i_rst_n, div_req.start, !div_rsp.busy, "divider started while busy")
    `VWAD_ASSERT_IMPLY(a_div_done_in_wait, i_clk, i_rst_n, div_rsp.done, r_state == ST_DIV, "divider finished outside its wait state")
    `VWAD_ASSERT_IMPLY(a_emit_only_final, i_clk, i_rst_n, r_state == ST_EMIT, r_cmd.final_sample, "result emitted for an element outside a final sample")
endmodule

// File: hdl/vector_window_average_decimator.sv
// An element of a final sample gets its averaged result from the 42-step
// divider lanes in the back end. Outside a final sample each element takes a
// sum memory read, then a write; an element of a final sample also waits on
// the divider and the output register. Reset is synchronous, active low;
// afterwards a clearing pass of the sum memory runs with input ready held low,
// while configuration writes are still taken.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector window average decimator
// Boxcar average over a window of samples, emitted once per window, for a
// stream of state and coupling vector elements.
// ----------------------------------------------------------------------------
module vector_window_average_decimator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    vwad_in_if.sink                    i_in,
    vwad_out_if.source                 o_out,
    input  logic                       i_cfg_wr_en,
    input  logic [vwad_pkg::LEN_W-1:0] i_cfg_wr_data
);
    import vwad_pkg::*;

    // The front end owns the window length register, the window position and
    // the time sum. It tags every element with the effective length, whether
    // it belongs to the final sample of a window, and the running time total
    // including this sample, so the back end never needs the window state.
    t_cmd    front_cmd;
    logic    front_push;

    // The queue lets the front keep taking elements of ordinary samples while
    // the back end is busy dividing or waiting on a stalled output.
    t_cmd    q_head;
    t_q_stat q_stat;
    logic    back_pop;
    logic    clear_done;

    vwad_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_stat      (q_stat),
        .i_clear_done  (clear_done),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    vwad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // The back end holds the per-element sums of both vectors in one memory.
    // It adds each element into its sum; in a final sample it clears the sum,
    // divides both the element sum and the time total by the window length,
    // saturates the means to 32 bits and loads the output register, which
    // stays there until the downstream side takes the transfer.
    vwad_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_stat     (q_stat),
        .o_pop        (back_pop),
        .o_clear_done (clear_done),
        .o_out        (o_out)
    );
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector window average decimator testbench
// Streams state and coupling vector elements into the decimator, predicts
// every window mean and mean time in a local model of the block and checks
// each averaged element against it, while both channels stall at random and
// the window length is changed between phases of traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import vwad_pkg::*;

    // One element as the sender presents it.
    typedef struct packed {
        logic                    sel;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       stamp;
        logic                    eos;
    } t_elem;

    // One averaged element as the block returns it.
    typedef struct packed {
        logic                    sel;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] avg;
        logic [TIME_W-1:0]       avg_stamp;
        logic                    last;
    } t_avg;

    // A row of the directed part: either a window length write or an element.
    // Where a result can be read off at a glance its mean and mean time are
    // typed in; select, index and last flag are copies of the element.
    typedef struct packed {
        logic                    is_cfg;
        logic [LEN_W-1:0]        cfg;
        logic                    sel;
        logic [IDX_W-1:0]        idx;
        logic [VAL_W-1:0]        value;
        logic [TIME_W-1:0]       stamp;
        logic                    eos;
        logic                    typed;
        logic [VAL_W-1:0]        x_avg;
        logic [TIME_W-1:0]       x_stamp;
    } t_dir_row;

    localparam logic CFG  = 1'b1;
    localparam logic ELEM = 1'b0;
    localparam logic CHK  = 1'b1;
    localparam logic PRED = 1'b0;

    localparam int  DIR_ROWS      = 25;
    localparam int  RANDOM_ITEMS  = 1030;
    // The back end divides in 42 steps; the settle time leaves margin for the
    // elements that are still on their way through the queue and sum memory.
    localparam int  SETTLE_CYCLES = 64;
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  PRINT_LIMIT   = 30;

    localparam longint MEAN_MAX = 64'sd2147483647;
    localparam longint MEAN_MIN = -64'sd2147483648;

    // Directed part. Reset leaves the window at one sample, so the first rows
    // average over a single sample and show the field extremes unchanged.
    // Then: a length of zero, a two-sample window with truncation toward zero,
    // an element repeated inside a sample so that its mean saturates high and
    // low, and a length lowered mid-window so that the mean time saturates.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{ELEM, 11'd0, 1'b0, 8'h00, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0,
          CHK, 32'h7FFF_FFFF, 32'h0001_0000},
        '{ELEM, 11'd0, 1'b1, 8'hFF, 32'h8000_0000, 32'h0001_0000, 1'b1,
          CHK, 32'h8000_0000, 32'h0001_0000},
        '{ELEM, 11'd0, 1'b0, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          CHK, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{CFG,  11'd0, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h03, 32'h0000_0005, 32'h0002_0000, 1'b1,
          CHK, 32'h0000_0005, 32'h0002_0000},
        '{CFG,  11'd2, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h01, 32'h0000_0003, 32'h0003_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h01, 32'hFFFF_FFFD, 32'h0003_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h01, 32'h0000_0000, 32'h0004_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h01, 32'h0000_0000, 32'h0004_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h07, 32'h7FFF_FFFF, 32'h0005_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h07, 32'h7FFF_FFFF, 32'h0005_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h07, 32'h7FFF_FFFF, 32'h0005_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h07, 32'h7FFF_FFFF, 32'h0005_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h07, 32'h7FFF_FFFF, 32'h0006_0000, 1'b1,
          CHK, 32'h7FFF_FFFF, 32'h0005_8000},
        '{ELEM, 11'd0, 1'b1, 8'h09, 32'h8000_0000, 32'h0007_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h09, 32'h8000_0000, 32'h0007_0000, 1'b0,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h09, 32'h8000_0000, 32'h0007_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b1, 8'h09, 32'h8000_0000, 32'h0008_0000, 1'b1,
          CHK, 32'h8000_0000, 32'h0007_8000},
        '{CFG,  11'd8, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h14, 32'h0001_0000, 32'hF000_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h14, 32'h0001_0000, 32'hF000_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h14, 32'h0001_0000, 32'hF000_0000, 1'b1,
          PRED, 32'h0, 32'h0},
        '{CFG,  11'd1, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, PRED, 32'h0, 32'h0},
        '{ELEM, 11'd0, 1'b0, 8'h14, 32'h0001_0000, 32'hF000_0000, 1'b1,
          PRED, 32'h0, 32'h0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;

    vwad_in_if  in_ch ();
    vwad_out_if avg_ch ();

    vector_window_average_decimator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (avg_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Local copy of the block state that the window means are computed from.
    logic [ACC_W-1:0]  state_acc    [MAX_ELEMENTS];
    logic [ACC_W-1:0]  coupling_acc [MAX_ELEMENTS];
    logic [ACC_W-1:0]  stamp_acc;
    logic [POS_W-1:0]  samples_done;
    logic [LEN_W-1:0]  len_setting;

    t_avg pending_means [$];

    // Typed-in expectation that goes with the element on the input channel.
    // It is driven by nonblocking assignment together with the element so
    // that the scoreboard sees the value that belongs to the transfer.
    logic             typed_on;
    logic [VAL_W-1:0] typed_avg;
    logic [TIME_W-1:0] typed_stamp;

    bit steady_flow;
    int out_hold;
    int cycle_count;
    int mismatch_count;
    int element_count;
    int result_count;
    int cfg_count;
    int phase_count;
    int random_items;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_means.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch in %s: got %h, expected %h (result %0d)",
                     $time, what, got, want, result_count);
    endtask

    // Fold one element into the local state. A sample is final when the
    // samples already completed plus this one reach the effective length;
    // a length of zero acts as one and lengths above the maximum window
    // are clamped. All 8-bit indexes are inside the element range, so
    // every element is accumulated.
    task automatic fold_element(input t_elem e, output bit emits, output t_avg r);
        longint           eff_len;
        longint           sum_s;
        longint           mean;
        longint unsigned  tmean;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] tsum;
        bit               closes_window;
        eff_len = (len_setting == 0) ? 1 :
                  (len_setting > MAX_WINDOW) ? MAX_WINDOW : len_setting;
        closes_window = (int'(samples_done) + 1) >= eff_len;
        acc = e.sel ? coupling_acc[e.idx] : state_acc[e.idx];
        acc = acc + {{(ACC_W - VAL_W){e.value[VAL_W-1]}}, e.value};
        r = '0;
        emits = closes_window;
        if (closes_window) begin
            sum_s = $signed(acc);
            mean = sum_s / eff_len;
            if (mean > MEAN_MAX)
                mean = MEAN_MAX;
            if (mean < MEAN_MIN)
                mean = MEAN_MIN;
            acc = '0;
            tsum = stamp_acc + e.stamp;
            tmean = tsum / eff_len;
            if (tmean > 64'h0000_0000_FFFF_FFFF)
                tmean = 64'h0000_0000_FFFF_FFFF;
            r.sel = e.sel;
            r.idx = e.idx;
            r.avg = mean[VAL_W-1:0];
            r.avg_stamp = tmean[TIME_W-1:0];
            r.last = e.eos;
        end
        if (e.sel)
            coupling_acc[e.idx] = acc;
        else
            state_acc[e.idx] = acc;
        if (e.eos) begin
            if (closes_window) begin
                stamp_acc = '0;
                samples_done = '0;
            end else begin
                stamp_acc = stamp_acc + e.stamp;
                samples_done = samples_done + 1'b1;
            end
        end
    endtask

    // Scoreboard. Everything is sampled at the rising edge, before the
    // nonblocking updates of that edge, so the order of processes within
    // the step does not matter. Input transfers are folded first; a result
    // never leaves in the cycle its own element arrives.
    always @(posedge i_clk) begin : scoreboard
        t_elem taken;
        t_avg  want;
        bit    emits;
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                len_setting = i_cfg_wr_data;
            if (in_ch.valid && in_ch.ready) begin
                taken.sel   = in_ch.vector_select;
                taken.idx   = in_ch.element_index;
                taken.value = in_ch.element_value;
                taken.stamp = in_ch.sample_time;
                taken.eos   = in_ch.end_of_sample;
                element_count++;
                fold_element(taken, emits, want);
                if (emits) begin
                    if (typed_on) begin
                        want.avg = typed_avg;
                        want.avg_stamp = typed_stamp;
                    end
                    pending_means.push_back(want);
                end
            end
            if (avg_ch.valid && avg_ch.ready) begin
                result_count++;
                if (pending_means.size() == 0) begin
                    report_mismatch("unrequested result",
                                    {avg_ch.out_vector_select, avg_ch.out_element_index},
                                    '0);
                end else begin
                    want = pending_means.pop_front();
                    if (avg_ch.out_vector_select !== want.sel)
                        report_mismatch("vector select", avg_ch.out_vector_select, want.sel);
                    if (avg_ch.out_element_index !== want.idx)
                        report_mismatch("element index", avg_ch.out_element_index, want.idx);
                    if (avg_ch.average_value !== want.avg)
                        report_mismatch("average value", avg_ch.average_value, want.avg);
                    if (avg_ch.average_time !== want.avg_stamp)
                        report_mismatch("average time", avg_ch.average_time, want.avg_stamp);
                    if (avg_ch.last_of_output !== want.last)
                        report_mismatch("last of output", avg_ch.last_of_output, want.last);
                end
            end
        end
    end

    // Result side: after each transfer the receiver may hold ready low for a
    // randomly drawn hold, except in phases of steady flow.
    initial begin : result_side
        avg_ch.ready = 1'b1;
        out_hold     = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold != 0) begin
                out_hold = out_hold - 1;
                if (out_hold == 0)
                    avg_ch.ready <= 1'b1;
            end else if (i_rst_n && avg_ch.valid && avg_ch.ready) begin
                out_hold = steady_flow ? 0 : $urandom_range(0, 5);
                if (out_hold != 0)
                    avg_ch.ready <= 1'b0;
            end
        end
    end

    // Present one element after a random gap and wait for its transfer.
    task automatic send_element(input t_elem e, input logic chk,
                                input logic [VAL_W-1:0] chk_avg,
                                input logic [TIME_W-1:0] chk_stamp);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.vector_select <= e.sel;
        in_ch.element_index <= e.idx;
        in_ch.element_value <= e.value;
        in_ch.sample_time   <= e.stamp;
        in_ch.end_of_sample <= e.eos;
        typed_on            <= chk;
        typed_avg           <= chk_avg;
        typed_stamp         <= chk_stamp;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    // The window length may only change while the block is idle: every
    // expected result has arrived and elements that produce no result have
    // had time to pass through the sum memory.
    task automatic write_window_length(input logic [LEN_W-1:0] len);
        in_ch.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cfg_count++;
    endtask

    // Element values: full-range words, small values around zero, or one of
    // the extremes, zero or minus one.
    function automatic logic [VAL_W-1:0] draw_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 2))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // One phase of random traffic at a given window length. Most samples
    // walk a fixed set of vector elements in order, skipping a few so that
    // absent elements carry their sums into the next window; about one in
    // eight is noise with random elements, times and sample ends.
    task automatic run_window_phase(input logic [LEN_W-1:0] len, input int samples,
                                    input int elems);
        logic             pool_sel [8];
        logic [IDX_W-1:0] pool_idx [8];
        logic [TIME_W-1:0] stamp;
        t_elem            e;
        int               n;
        write_window_length(len);
        steady_flow = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < elems; k++) begin
            pool_sel[k] = $urandom_range(0, 1);
            pool_idx[k] = $urandom_range(0, MAX_ELEMENTS - 1);
        end
        stamp = $urandom;
        for (int s = 0; s < samples; s++) begin
            stamp = stamp + $urandom_range(1, 32'h0008_0000);
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    e.sel   = $urandom_range(0, 1);
                    e.idx   = $urandom_range(0, MAX_ELEMENTS - 1);
                    e.value = $urandom;
                    e.stamp = $urandom;
                    e.eos   = $urandom_range(0, 1);
                    send_element(e, PRED, '0, '0);
                    random_items++;
                end
            end else begin
                for (int k = 0; k < elems; k++) begin
                    if (k != elems - 1 && $urandom_range(0, 5) == 0)
                        continue;
                    e.sel   = pool_sel[k];
                    e.idx   = pool_idx[k];
                    e.value = draw_value();
                    e.stamp = stamp;
                    e.eos   = (k == elems - 1);
                    send_element(e, PRED, '0, '0);
                    random_items++;
                end
            end
        end
    endtask

    initial begin
        logic [LEN_W-1:0] len;
        int               eff;
        int               samples;
        int               elems;
        t_elem            e;

        // Every input known from time zero; the model starts from reset.
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        in_ch.valid         = 1'b0;
        in_ch.vector_select = 1'b0;
        in_ch.element_index = '0;
        in_ch.element_value = '0;
        in_ch.sample_time   = '0;
        in_ch.end_of_sample = 1'b0;
        typed_on            = 1'b0;
        typed_avg           = '0;
        typed_stamp         = '0;
        foreach (state_acc[i]) begin
            state_acc[i]    = '0;
            coupling_acc[i] = '0;
        end
        stamp_acc    = '0;
        samples_done = '0;
        len_setting  = 11'd1;
        steady_flow  = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Input ready stays low during the clearing pass that
        // follows reset; the first transfer simply waits for it.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].is_cfg) begin
                write_window_length(directed_rows[r].cfg);
            end else begin
                e.sel   = directed_rows[r].sel;
                e.idx   = directed_rows[r].idx;
                e.value = directed_rows[r].value;
                e.stamp = directed_rows[r].stamp;
                e.eos   = directed_rows[r].eos;
                send_element(e, directed_rows[r].typed, directed_rows[r].x_avg,
                             directed_rows[r].x_stamp);
            end
        end

        // Random phases. A phase may stop mid-window, so the next phase,
        // often with a shorter length, starts with a window already open.
        // Long settings, including one above the maximum window, only get a
        // few samples and leave their window open for the next phase.
        while (random_items < RANDOM_ITEMS) begin
            phase_count++;
            case ($urandom_range(0, 7))
                0: len = 11'd0;
                1: len = 11'd1;
                2: len = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
                3: len = 11'd16;
                default: len = $urandom_range(2, 6);
            endcase
            eff = (len == 0) ? 1 : int'(len);
            if (len >= 11'd1024)
                samples = $urandom_range(2, 6);
            else
                samples = $urandom_range(eff, 3 * eff + 2);
            elems = (len == 11'd16) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            run_window_phase(len, samples, elems);
        end

        in_ch.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d element transfers (%0d directed rows) and %0d averaged results,",
                 element_count, DIR_ROWS, result_count);
        $display("with %0d window length writes over %0d random phases; %0d mismatches.",
                 cfg_count, phase_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
